FILE: rtl/slt_pkg.sv
package slt_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DESC_RD,
		ST_DESC,
		ST_INS0,
		ST_ASC_RD,
		ST_ASC,
		ST_EDGE_LO,
		ST_EDGE_HI,
		ST_EDGE_END,
		ST_RESP
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] value;
	} slt_in_t;

	typedef struct packed {
		status_t            status;
		logic               hit;
		logic [4:0]         entry_count;
		logic signed [31:0] smallest;
		logic signed [31:0] largest;
		logic               empty_res;
	} slt_out_t;

endpackage

FILE: rtl/sorted_list_table.sv
// insert walks down from the tail, delete/search walk up from the head,
// one stored entry per cycle through the single ram read port and one comparator;
// done marks the response; clear, a full insert and a delete or search on an empty
// table go straight to the response state; a walk visits at most CAPACITY entries;
// busy stays high until done, so a new item is taken only after the last one is through.
// reset clears the count and the sequencer, not the entry ram; the receiver cannot stall.
module sorted_list_table
	import slt_pkg::*;
#(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  slt_in_t  cmd,
	output logic     done,
	output slt_out_t result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	mode_t                   mode_q, mode_d;
	logic signed [VALUE_WIDTH-1:0] v_q, v_d;
	logic [CW-1:0]           cnt_q, cnt_d;
	logic [AW-1:0]           idx_q, idx_d;
	logic                    found_q, found_d;
	status_t                 status_q, status_d;
	logic                    hit_q, hit_d;
	logic signed [VALUE_WIDTH-1:0] min_q, min_d;
	logic signed [VALUE_WIDTH-1:0] max_q, max_d;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [VALUE_WIDTH-1:0]  ram_wdata;
	logic [AW-1:0]           ram_raddr;
	logic [VALUE_WIDTH-1:0]  ram_rdata;

	logic signed [VALUE_WIDTH-1:0] rd_val;
	logic signed [63:0]      in_ext;
	logic                    rd_lt;
	logic                    rd_eq;
	logic [CW-1:0]           cnt_m1;
	logic [AW-1:0]           last_idx;
	logic                    is_last;
	logic                    is_empty;
	logic                    is_full;

	slt_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared comparator: stored entry against the item value
	assign rd_val   = ram_rdata;
	assign rd_lt    = rd_val < v_q;
	assign rd_eq    = rd_val == v_q;
	assign in_ext   = 64'(cmd.value);
	assign cnt_m1   = cnt_q - CW'(1);
	assign last_idx = cnt_m1[AW-1:0];
	assign is_last  = idx_q == last_idx;
	assign is_empty = cnt_q == '0;
	assign is_full  = cnt_q == CW'(CAPACITY);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.mode)
						MODE_INSERT: state_d = is_full ? ST_RESP : ST_DESC_RD;
						MODE_DELETE,
						MODE_SEARCH: state_d = is_empty ? ST_RESP : ST_ASC_RD;
						default:     state_d = ST_RESP;
					endcase
				end
			end
			ST_DESC_RD: state_d = is_empty ? ST_INS0 : ST_DESC;
			ST_DESC: begin
				if (!rd_lt) begin
					state_d = (idx_q == '0) ? ST_INS0 : ST_DESC;
				end else begin
					state_d = ST_EDGE_LO;
				end
			end
			ST_INS0:   state_d = ST_EDGE_LO;
			ST_ASC_RD: state_d = ST_ASC;
			ST_ASC: begin
				if (found_q) begin
					state_d = is_last ? ST_EDGE_LO : ST_ASC;
				end else if (rd_lt) begin
					state_d = is_last ? ST_RESP : ST_ASC;
				end else if (rd_eq) begin
					if (mode_q == MODE_SEARCH) begin
						state_d = ST_RESP;
					end else begin
						state_d = is_last ? ST_EDGE_LO : ST_ASC;
					end
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_EDGE_LO:  state_d = is_empty ? ST_RESP : ST_EDGE_HI;
			ST_EDGE_HI:  state_d = ST_EDGE_END;
			ST_EDGE_END: state_d = ST_RESP;
			ST_RESP:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mode_d    = mode_q;
		v_d       = v_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		found_d   = found_q;
		status_d  = status_q;
		hit_d     = hit_q;
		min_d     = min_q;
		max_d     = max_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q + AW'(1);
		ram_wdata = rd_val;
		ram_raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					mode_d   = cmd.mode;
					v_d      = in_ext[VALUE_WIDTH-1:0];
					idx_d    = last_idx;
					found_d  = 1'b0;
					status_d = STAT_DONE;
					hit_d    = 1'b0;
					case (cmd.mode)
						MODE_INSERT: begin
							if (is_full) begin
								status_d = STAT_FULL;
							end
						end
						MODE_DELETE: begin
							if (is_empty) begin
								status_d = STAT_EMPTY;
							end
						end
						MODE_CLEAR:  cnt_d = '0;
						default: ;
					endcase
				end
			end
			ST_DESC_RD: ram_raddr = idx_q;
			ST_DESC: begin
				// shift entries not less than the value up by one
				ram_we = 1'b1;
				if (!rd_lt) begin
					ram_wdata = rd_val;
					ram_raddr = idx_q - AW'(1);
					idx_d     = idx_q - AW'(1);
				end else begin
					ram_wdata = v_q;
					cnt_d     = cnt_q + CW'(1);
				end
			end
			ST_INS0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = v_q;
				cnt_d     = cnt_q + CW'(1);
			end
			ST_ASC_RD: begin
				ram_raddr = '0;
				idx_d     = '0;
			end
			ST_ASC: begin
				ram_raddr = idx_q + AW'(1);
				idx_d     = idx_q + AW'(1);
				if (found_q) begin
					// close the gap left by the removed entry
					ram_we    = 1'b1;
					ram_waddr = idx_q - AW'(1);
					ram_wdata = rd_val;
					if (is_last) begin
						cnt_d = cnt_m1;
					end
				end else if (rd_lt) begin
					if (is_last && mode_q == MODE_DELETE) begin
						status_d = STAT_NOT_FOUND;
					end
				end else if (rd_eq) begin
					hit_d = 1'b1;
					if (mode_q == MODE_DELETE) begin
						found_d = 1'b1;
						if (is_last) begin
							cnt_d = cnt_m1;
						end
					end
				end else if (mode_q == MODE_DELETE) begin
					status_d = STAT_NOT_FOUND;
				end
			end
			ST_EDGE_LO: ram_raddr = '0;
			ST_EDGE_HI: begin
				min_d     = rd_val;
				ram_raddr = last_idx;
			end
			ST_EDGE_END: max_d = rd_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			status_q <= STAT_DONE;
			hit_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			found_q  <= found_d;
			status_q <= status_d;
			hit_q    <= hit_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		v_q    <= v_d;
		idx_q  <= idx_d;
		min_q  <= min_d;
		max_q  <= max_d;
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_RESP;

	always_comb begin
		result.status      = status_q;
		result.hit         = hit_q;
		result.entry_count = 5'(cnt_q);
		result.empty_res   = is_empty;
		if (is_empty) begin
			result.smallest = '0;
			result.largest  = '0;
		end else begin
			result.smallest = 32'(64'(min_q));
			result.largest  = 32'(64'(max_q));
		end
	end

endmodule

FILE: rtl/slt_ram.sv
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: tb/sorted_list_table_test.sv
module sorted_list_table_test;
	timeunit 1ns;
	timeprecision 1ps;
	import slt_pkg::*;

	localparam int CAP         = 16;
	localparam int STALL_LIMIT = 1000;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	slt_in_t  cmd    = '0;
	logic     busy;
	logic     done;
	slt_out_t result;

	sorted_list_table #(.CAPACITY(CAP), .VALUE_WIDTH(32)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// shadow copy of the table, ascending, first table_count entries valid
	logic signed [31:0] table_vals [CAP];
	int                 table_count = 0;
	slt_out_t           pending_results [$];
	slt_out_t           oldest;
	int                 errors       = 0;
	int                 quiet_cycles = 0;
	bit                 idle_on      = 1'b1;

	function automatic slt_out_t apply_word(slt_in_t c);
		slt_out_t r;
		int       pos;
		r = '0;
		r.status = STAT_DONE;
		pos = 0;
		while (pos < table_count && table_vals[pos] < $signed(c.value))
			pos++;
		case (c.mode)
			MODE_INSERT: begin
				if (table_count >= CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (int k = table_count; k > pos; k--)
						table_vals[k] = table_vals[k - 1];
					table_vals[pos] = c.value;
					table_count++;
				end
			end
			MODE_DELETE: begin
				if (table_count == 0) begin
					r.status = STAT_EMPTY;
				end else if (pos < table_count && table_vals[pos] == c.value) begin
					for (int k = pos; k + 1 < table_count; k++)
						table_vals[k] = table_vals[k + 1];
					table_count--;
					r.hit = 1'b1;
				end else begin
					r.status = STAT_NOT_FOUND;
				end
			end
			MODE_SEARCH: begin
				if (pos < table_count && table_vals[pos] == c.value)
					r.hit = 1'b1;
			end
			default: begin
				table_count = 0;
			end
		endcase
		r.entry_count = table_count[4:0];
		if (table_count == 0) begin
			r.empty_res = 1'b1;
		end else begin
			r.smallest = table_vals[0];
			r.largest  = table_vals[table_count - 1];
		end
		return r;
	endfunction

	task automatic report_field(string name, logic signed [32:0] want, logic signed [32:0] got);
		errors++;
		$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
	endtask

	// results are checked before the word accepted at the same edge is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none actual %p",
						$time, result);
				end else begin
					oldest = pending_results.pop_front();
					if (result.status !== oldest.status)
						report_field("status", oldest.status, result.status);
					if (result.hit !== oldest.hit)
						report_field("hit", oldest.hit, result.hit);
					if (result.entry_count !== oldest.entry_count)
						report_field("entry_count", oldest.entry_count, result.entry_count);
					if (result.smallest !== oldest.smallest)
						report_field("smallest", oldest.smallest, result.smallest);
					if (result.largest !== oldest.largest)
						report_field("largest", oldest.largest, result.largest);
					if (result.empty_res !== oldest.empty_res)
						report_field("empty_res", oldest.empty_res, result.empty_res);
				end
			end
			if (start && !busy)
				pending_results.push_back(apply_word(cmd));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// returns at the accepting edge with start still high
	task automatic send_word(mode_t m, logic signed [31:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= '{mode: m, value: v};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// one edge first so the word accepted last is already queued
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (table_count > 0 && r < 50)
			return table_vals[$urandom_range(0, table_count - 1)];
		if (r < 72)
			return $signed(32'($urandom_range(0, 8))) - 32'sd4;
		if (r < 76)
			return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
		return $urandom();
	endfunction

	function automatic mode_t pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return MODE_INSERT;
		if (r < 75) return MODE_DELETE;
		if (r < 97) return MODE_SEARCH;
		return MODE_CLEAR;
	endfunction

	task automatic test_edge_values();
		send_word(MODE_SEARCH, 32'sd0);
		send_word(MODE_DELETE, 32'sd5);
		send_word(MODE_CLEAR, 32'sd0);
		send_word(MODE_INSERT, 32'sh7fffffff);
		send_word(MODE_INSERT, 32'sh80000000);
		send_word(MODE_INSERT, 32'sd0);
		send_word(MODE_INSERT, -32'sd1);
		send_word(MODE_INSERT, 32'sd0);
		send_word(MODE_SEARCH, 32'sh7fffffff);
		send_word(MODE_SEARCH, 32'sd1);
		send_word(MODE_DELETE, 32'sd1);
		send_word(MODE_DELETE, 32'sd0);
		send_word(MODE_DELETE, 32'sh80000000);
		send_word(MODE_DELETE, 32'sh7fffffff);
		send_word(MODE_SEARCH, 32'sd0);
		send_word(MODE_INSERT, 32'sh55555555);
		send_word(MODE_INSERT, 32'shaaaaaaaa);
		send_word(MODE_CLEAR, -32'sd1);
		send_word(MODE_SEARCH, 32'shaaaaaaaa);
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 1000; i++) begin
			if (i % 100 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_word(pick_mode(), pick_value());
		end
		idle_on = 1'b1;
	endtask

	// fill past capacity, then delete from it again with hits, misses and searches
	task automatic test_fill_drain();
		for (int round = 0; round < 20; round++) begin
			idle_on = (round % 3 != 2);
			repeat (CAP + $urandom_range(1, 3)) begin
				if ($urandom_range(0, 4) == 0)
					send_word(MODE_SEARCH, pick_value());
				send_word(MODE_INSERT, pick_value());
			end
			repeat (CAP + $urandom_range(1, 4)) begin
				if ($urandom_range(0, 4) == 0)
					send_word(MODE_SEARCH, pick_value());
				if (table_count > 0 && $urandom_range(0, 9) < 7)
					send_word(MODE_DELETE, table_vals[$urandom_range(0, table_count - 1)]);
				else
					send_word(MODE_DELETE, $urandom());
			end
			if (round % 5 == 4)
				drain();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		for (int i = 0; i < 200; i++)
			send_word(pick_mode(), pick_value());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_values();
		drain();
		test_random_mix();
		drain();
		test_fill_drain();
		drain();
		test_back_to_back();
		drain();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sorted_list_table.f
rtl/slt_pkg.sv
rtl/slt_ram.sv
rtl/sorted_list_table.sv
tb/sorted_list_table_test.sv
